>>> hdl/pp_pkg.sv
// Shared types and constants of the point projection block.
package pp_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W = 32;
	localparam int IDX_W = 4;
	localparam int REQ_W = 2;
	localparam int VIEW_W = 16;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		REQ_LOAD_MODEL = 2'd0,
		REQ_LOAD_PROJ  = 2'd1,
		REQ_PROJECT    = 2'd2,
		REQ_UNUSED     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_VIEW_X      = 2'd0,
		CFG_VIEW_Y      = 2'd1,
		CFG_VIEW_WIDTH  = 2'd2,
		CFG_VIEW_HEIGHT = 2'd3
	} cfg_reg_t;

	// Clamp a 64 bit signed value into 32 bits signed.
	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) sat32 = 32'sh7FFF_FFFF;
		else if (v < lo) sat32 = 32'sh8000_0000;
		else sat32 = v[WORD_W-1:0];
	endfunction

	// Divider control between sequencer and divider.
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

>>> hdl/pp_div.sv
// Serial signed divider, one quotient bit per cycle, saturating result.
module pp_div import pp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [WORD_W-1:0] num,
	input  logic signed [WORD_W-1:0] den,
	output logic                     busy,
	output logic                     done,
	output logic signed [WORD_W-1:0] quo
);
	localparam int NW = WORD_W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]     rem_num_q;
	logic [NW:0]       rem_q;
	logic [WORD_W-1:0] den_abs_q;
	logic              neg_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NW:0]       trial;
	logic [NW:0]       shifted;
	logic [NW-1:0]     num_abs;
	logic signed [63:0] qs;

	assign num_abs = num[WORD_W-1] ? NW'(-{{FRAC_BITS{num[WORD_W-1]}}, num}) << FRAC_BITS
		: NW'({{FRAC_BITS{1'b0}}, num}) << FRAC_BITS;
	assign shifted = {rem_q[NW-1:0], rem_num_q[NW-1]};
	assign trial = shifted - (NW+1)'(den_abs_q);

	// Shift in one numerator bit per cycle, restoring subtract.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_num_q <= num_abs;
			rem_q <= '0;
			den_abs_q <= den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
			neg_q <= num[WORD_W-1] ^ den[WORD_W-1];
		end else if (busy_q) begin
			if (!trial[NW]) rem_q <= trial;
			else rem_q <= shifted;
			rem_num_q <= {rem_num_q[NW-2:0], ~trial[NW]};
		end
	end

	// Quotient bits accumulate in rem_num_q.
	always_comb begin
		qs = neg_q ? -64'(rem_num_q) : 64'(rem_num_q);
		quo = sat32(qs);
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule

>>> hdl/point_projection.sv
// Top level of the point projection block: matrices, MAC sequencer, mapping.
// A project word is taken only from idle. The sequencer runs eight matrix
// rows (model then projection), each issuing its four products, draining
// the product register and saturating; then three divides, each of which
// starts, produces 32+FRAC_BITS quotient bits and hands off; then a mapping
// step and the output state. The next word is taken the cycle after the
// result leaves; a zero clip w skips the divides and the mapping step. A load
// word is written when accepted and leaves the sequencer idle. A single 32x32
// multiply-accumulate and a single bit-serial divider do this work. in_stall
// is high while a word is in work or a result waits to be taken.
module point_projection import pp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [REQ_W-1:0]         req_type,
	input  logic [IDX_W-1:0]         entry_index,
	input  logic signed [WORD_W-1:0] entry_value,
	input  logic signed [WORD_W-1:0] obj_x,
	input  logic signed [WORD_W-1:0] obj_y,
	input  logic signed [WORD_W-1:0] obj_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] win_x,
	output logic signed [WORD_W-1:0] win_y,
	output logic signed [WORD_W-1:0] win_z,
	output logic                     ok,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [WORD_W-1:0]        cfg_data
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MAC  = 6'b000010,
		ST_SAT  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_MAP  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic signed [WORD_W-1:0] model_q [16];
	logic signed [WORD_W-1:0] proj_q [16];
	logic signed [VIEW_W-1:0] view_x_q, view_y_q;
	logic [VIEW_W-1:0]        view_w_q, view_h_q;
	logic signed [WORD_W-1:0] vec_q [4];
	logic signed [WORD_W-1:0] res_q [4];
	logic signed [WORD_W-1:0] ndc_q [3];
	logic signed [63:0]       acc_q;
	logic signed [63:0]       prod_s1;
	logic                     prod_vld_s1;
	logic                     pass_q;
	logic [1:0]               row_q, col_q, dsel_q;
	logic                     issue_q;
	logic signed [WORD_W-1:0] mat_rd, vec_rd;
	logic                     accept;
	div_ctl_t                 dctl;
	logic signed [WORD_W-1:0] quo;
	logic signed [WORD_W-1:0] ow_x_q, ow_y_q, ow_z_q;
	logic                     ok_q, out_valid_q;
	logic signed [63:0]       nx, ny, nz, mx, my;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Write viewport registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q <= '0;
			view_y_q <= '0;
			view_w_q <= '0;
			view_h_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_VIEW_X:      view_x_q <= cfg_data[VIEW_W-1:0];
				CFG_VIEW_Y:      view_y_q <= cfg_data[VIEW_W-1:0];
				CFG_VIEW_WIDTH:  view_w_q <= cfg_data[VIEW_W-1:0];
				CFG_VIEW_HEIGHT: view_h_q <= cfg_data[VIEW_W-1:0];
				default: ;
			endcase
		end
	end

	// Load matrix entries.
	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_LOAD_MODEL) model_q[entry_index] <= entry_value;
		if (accept && req_type == REQ_LOAD_PROJ) proj_q[entry_index] <= entry_value;
	end

	assign mat_rd = pass_q ? proj_q[{col_q, row_q}] : model_q[{col_q, row_q}];
	assign vec_rd = vec_q[col_q];

	// Shared MAC: registered product, then floor shift and accumulate.
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mat_rd) * 64'(vec_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prod_vld_s1 <= 1'b0;
		else prod_vld_s1 <= issue_q;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			issue_q <= 1'b0;
			pass_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
			dsel_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_type == REQ_PROJECT) begin
						state_q <= ST_MAC;
						issue_q <= 1'b1;
						pass_q <= 1'b0;
						row_q <= '0;
						col_q <= '0;
					end
				end
				ST_MAC: begin
					if (issue_q) begin
						col_q <= col_q + 1'b1;
						if (col_q == 2'd3) begin
							issue_q <= 1'b0;
						end
					end
					if (prod_vld_s1 && !issue_q) state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (row_q == 2'd3) begin
						row_q <= '0;
						if (pass_q) begin
							state_q <= ST_DIV;
							dsel_q <= '0;
						end else begin
							pass_q <= 1'b1;
							state_q <= ST_MAC;
							issue_q <= 1'b1;
						end
					end else begin
						row_q <= row_q + 1'b1;
						state_q <= ST_MAC;
						issue_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (res_q[3] == '0) begin
						state_q <= ST_OUT;
						out_valid_q <= 1'b1;
					end else if (dctl.done) begin
						if (dsel_q == 2'd2) state_q <= ST_MAP;
						else dsel_q <= dsel_q + 1'b1;
					end
				end
				ST_MAP: begin
					state_q <= ST_OUT;
					out_valid_q <= 1'b1;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Load the vector, accumulate one row, store saturated row result and quotients.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			vec_q[0] <= obj_x;
			vec_q[1] <= obj_y;
			vec_q[2] <= obj_z;
			vec_q[3] <= WORD_W'(64'sd1 <<< FRAC_BITS);
			acc_q <= '0;
		end else if (state_q == ST_MAC && prod_vld_s1) begin
			acc_q <= acc_q + (prod_s1 >>> FRAC_BITS);
		end else if (state_q == ST_SAT) begin
			res_q[row_q] <= sat32(acc_q);
			acc_q <= '0;
			if (row_q == 2'd3 && !pass_q) begin
				vec_q[0] <= res_q[0];
				vec_q[1] <= res_q[1];
				vec_q[2] <= res_q[2];
				vec_q[3] <= sat32(acc_q);
			end
		end
		if (state_q == ST_DIV && dctl.done) ndc_q[dsel_q] <= quo;
	end

	assign dctl.start = (state_q == ST_DIV) && !dctl.busy && !dctl.done
		&& (res_q[3] != '0);

	pp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dctl.start),
		.num(res_q[dsel_q]), .den(res_q[3]),
		.busy(dctl.busy), .done(dctl.done), .quo(quo)
	);

	// Map to window coordinates.
	always_comb begin
		nx = 64'(ndc_q[0]) + (64'sd1 <<< FRAC_BITS);
		ny = 64'(ndc_q[1]) + (64'sd1 <<< FRAC_BITS);
		nz = 64'(ndc_q[2]) + (64'sd1 <<< FRAC_BITS);
		mx = nx * $signed({48'd0, view_w_q});
		my = ny * $signed({48'd0, view_h_q});
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MAP) begin
			ow_x_q <= sat32((mx >>> 1) + (64'(view_x_q) <<< FRAC_BITS));
			ow_y_q <= sat32((my >>> 1) + (64'(view_y_q) <<< FRAC_BITS));
			ow_z_q <= sat32(nz >>> 1);
			ok_q <= 1'b1;
		end else if (state_q == ST_DIV && res_q[3] == '0) begin
			ow_x_q <= '0;
			ow_y_q <= '0;
			ow_z_q <= '0;
			ok_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign win_x = ow_x_q;
	assign win_y = ow_y_q;
	assign win_z = ow_z_q;
	assign ok = ok_q;

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("accept while busy");
	a_out_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT) else $error("result outside output state");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.done |-> state_q == ST_DIV) else $error("divide done out of place");
endmodule

>>> tb/sv/point_projection_tb.sv
// Self-checking testbench for the point projection block.
`timescale 1ns / 100ps

module point_projection_tb;
	import pp_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FB;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [REQ_W-1:0] req_type;
	logic [IDX_W-1:0] entry_index;
	logic signed [31:0] entry_value, obj_x, obj_y, obj_z;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] win_x, win_y, win_z;
	logic ok;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic ok;
	} win_word_t;

	// Predictor state
	logic signed [31:0] model_m[16];
	logic signed [31:0] proj_m[16];
	logic signed [63:0] vp_x, vp_y, vp_w, vp_h;
	win_word_t win_queue[$];
	int errors;
	bit long_stalls;

	point_projection dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic signed [63:0] floor_sh(input logic signed [63:0] v, input int n);
		return v >>> n;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Apply one 4x4 column-major matrix to a vector
	function automatic void transform(input logic signed [31:0] m[16],
		input logic signed [31:0] v[4], output logic signed [31:0] r[4]);
		logic signed [63:0] acc;
		for (int row = 0; row < 4; row++) begin
			acc = 0;
			for (int col = 0; col < 4; col++)
				acc += floor_sh(64'(m[col*4+row]) * 64'(v[col]), FB);
			r[row] = clamp32(acc);
		end
	endfunction

	function automatic logic signed [31:0] qdiv(input logic signed [31:0] n,
		input logic signed [31:0] d);
		logic signed [63:0] num;
		num = 64'(n) <<< FB;
		return clamp32(num / 64'(d));
	endfunction

	function automatic win_word_t project_point(input logic signed [31:0] px,
		input logic signed [31:0] py, input logic signed [31:0] pz);
		logic signed [31:0] obj[4], eye[4], clip[4];
		logic signed [63:0] nx, ny, nz;
		win_word_t w;
		obj[0] = px; obj[1] = py; obj[2] = pz; obj[3] = ONE;
		transform(model_m, obj, eye);
		transform(proj_m, eye, clip);
		if (clip[3] == 0) return '0;
		nx = 64'(qdiv(clip[0], clip[3])) + 64'(ONE);
		ny = 64'(qdiv(clip[1], clip[3])) + 64'(ONE);
		nz = 64'(qdiv(clip[2], clip[3])) + 64'(ONE);
		w.x = clamp32(floor_sh(nx * vp_w, 1) + vp_x * 64'(ONE));
		w.y = clamp32(floor_sh(ny * vp_h, 1) + vp_y * 64'(ONE));
		w.z = clamp32(floor_sh(nz, 1));
		w.ok = 1'b1;
		return w;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	// Send one input word and predict its result; valid stays up until the
	// next word or an idle gap takes its place
	task automatic send_word(input req_t kind, input logic [3:0] idx,
		input logic signed [31:0] val, input logic signed [31:0] px,
		input logic signed [31:0] py, input logic signed [31:0] pz);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		entry_index <= idx;
		entry_value <= val;
		obj_x <= px;
		obj_y <= py;
		obj_z <= pz;
		do @(posedge clk); while (in_stall);
		case (kind)
			REQ_LOAD_MODEL: model_m[idx] = val;
			REQ_LOAD_PROJ: proj_m[idx] = val;
			REQ_PROJECT: win_queue.push_back(project_point(px, py, pz));
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Wait for the block to drain, then write one viewport register
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		in_valid <= 1'b0;
		while (win_queue.size() != 0) @(negedge clk);
		repeat (250) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= {16'h0, val};
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_VIEW_X: vp_x = $signed(val);
			CFG_VIEW_Y: vp_y = $signed(val);
			CFG_VIEW_WIDTH: vp_w = {48'h0, val};
			default: vp_h = {48'h0, val};
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_view(input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] w, input logic [15:0] h);
		write_reg(CFG_VIEW_X, x);
		write_reg(CFG_VIEW_Y, y);
		write_reg(CFG_VIEW_WIDTH, w);
		write_reg(CFG_VIEW_HEIGHT, h);
	endtask

	task automatic load_matrix(input req_t kind, input logic signed [31:0] m[16]);
		for (int i = 0; i < 16; i++)
			send_word(kind, i[3:0], m[i], rand_word(), rand_word(), rand_word());
	endtask

	function automatic void identity(output logic signed [31:0] m[16]);
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : 32'sd0;
	endfunction

	// Directed: identity, zero w, tiny w, extremes, ignored type
	task automatic test_directed();
		logic signed [31:0] m[16];
		identity(m);
		load_matrix(REQ_LOAD_MODEL, m);
		load_matrix(REQ_LOAD_PROJ, m);
		send_word(REQ_PROJECT, 4'hF, 32'sh7FFF_FFFF, 32'sh0000_8000, -32'sh0000_8000, 0);
		send_word(REQ_PROJECT, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_word(REQ_PROJECT, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_word(REQ_UNUSED, 4'hF, 32'sh8000_0000, 0, 0, 0);
		// clip w becomes zero
		send_word(REQ_LOAD_PROJ, 4'd15, 0, 0, 0, 0);
		send_word(REQ_PROJECT, 0, 0, ONE, ONE, ONE);
		// tiny w drives the divide into saturation
		send_word(REQ_LOAD_PROJ, 4'd15, 32'sd1, 0, 0, 0);
		send_word(REQ_PROJECT, 0, 0, ONE, -ONE, 32'sh7FFF_FFFF);
		send_word(REQ_LOAD_PROJ, 4'd15, -32'sd1, 0, 0, 0);
		send_word(REQ_PROJECT, 0, 0, -ONE, ONE, 32'sh8000_0000);
	endtask

	// Random: fresh matrices now and then, mostly projections
	task automatic test_random(input int count);
		logic signed [31:0] m[16];
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				for (int k = 0; k < 16; k++) m[k] = rand_word();
				if ($urandom_range(0, 3) == 0) m[$urandom_range(0, 15)] = 0;
				load_matrix(($urandom_range(0, 1) != 0) ? REQ_LOAD_MODEL : REQ_LOAD_PROJ, m);
				i += 16;
			end else if (r < 14) begin
				send_word(($urandom_range(0, 1) != 0) ? REQ_LOAD_MODEL : REQ_LOAD_PROJ,
					4'($urandom_range(0, 15)), rand_word(), rand_word(), rand_word(),
					rand_word());
			end else if (r < 16) begin
				send_word(REQ_UNUSED, 4'($urandom_range(0, 15)), rand_word(), rand_word(),
					rand_word(), rand_word());
			end else begin
				send_word(REQ_PROJECT, 4'($urandom_range(0, 15)), rand_word(), rand_word(),
					rand_word(), rand_word());
			end
		end
	endtask

	// Settings sweep, extremes included
	task automatic test_viewports();
		set_view(16'h0000, 16'h0000, 16'd640, 16'd480);
		test_random(400);
		set_view(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
		test_random(400);
		set_view(16'h7FFF, 16'h8000, 16'h0000, 16'd1);
		test_random(350);
		set_view(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		test_random(350);
	endtask

	// Result check and receiver stalls
	always @(posedge clk) begin
		win_word_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (win_queue.size() == 0) begin
				$display("%0t: unexpected word x=%h y=%h z=%h ok=%b",
					$time, win_x, win_y, win_z, ok);
				errors++;
			end else begin
				exp_w = win_queue.pop_front();
				if (exp_w.x !== win_x) begin
					$display("%0t: win_x exp %h got %h", $time, exp_w.x, win_x);
					errors++;
				end
				if (exp_w.y !== win_y) begin
					$display("%0t: win_y exp %h got %h", $time, exp_w.y, win_y);
					errors++;
				end
				if (exp_w.z !== win_z) begin
					$display("%0t: win_z exp %h got %h", $time, exp_w.z, win_z);
					errors++;
				end
				if (exp_w.ok !== ok) begin
					$display("%0t: ok exp %b got %b", $time, exp_w.ok, ok);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!long_stalls) out_stall <= 1'b0;
		else if ($urandom_range(0, 49) == 0) out_stall <= 1'b1;
		else if (out_stall && $urandom_range(0, 9) != 0) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	initial begin
		int guard;
		errors = 0;
		long_stalls = 1'b0;
		vp_x = 0; vp_y = 0; vp_w = 0; vp_h = 0;
		for (int i = 0; i < 16; i++) begin
			model_m[i] = 0;
			proj_m[i] = 0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD_MODEL;
		entry_index = 0;
		entry_value = 0;
		obj_x = 0;
		obj_y = 0;
		obj_z = 0;
		cfg_valid = 1'b0;
		cfg_index = CFG_VIEW_X;
		cfg_data = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		set_view(16'd10, 16'hFFF6, 16'd100, 16'd50);
		test_directed();
		long_stalls = 1'b1;
		test_viewports();
		in_valid <= 1'b0;
		guard = 0;
		while (win_queue.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (300) @(negedge clk);
		if (errors == 0 && win_queue.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

>>> files.f
hdl/pp_pkg.sv
hdl/pp_div.sv
hdl/point_projection.sv
tb/sv/point_projection_tb.sv
